[rtl/sdp_pkg.sv]
// Shared types and constants for the SMS-DELIVER PDU parser.
`default_nettype none

package sdp_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_SCA_LEN,
    PH_SCA_SKIP,
    PH_FIRST,
    PH_ADDR_LEN,
    PH_ADDR_TYPE,
    PH_ADDR_DIGITS,
    PH_PID,
    PH_CODING,
    PH_STAMP,
    PH_UDL,
    PH_MSG,
    PH_DRAIN
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_DIGIT  = 2'd0;
  localparam logic [1:0] KIND_OCTET  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_TRUNCATED     = 4'd1;
  localparam logic [3:0] ST_BAD_SCA_LEN   = 4'd2;
  localparam logic [3:0] ST_NOT_DELIVER   = 4'd3;
  localparam logic [3:0] ST_BAD_ADDR_LEN  = 4'd4;
  localparam logic [3:0] ST_BAD_ADDR_TYPE = 4'd5;
  localparam logic [3:0] ST_BAD_DIGIT     = 4'd6;
  localparam logic [3:0] ST_BAD_CODING    = 4'd7;
  localparam logic [3:0] ST_TOO_LONG      = 4'd8;

  // Configuration register indexes
  localparam logic CFG_MAX_SENDER_DIGITS  = 1'b0;
  localparam logic CFG_MAX_MESSAGE_OCTETS = 1'b1;

  // Protocol constants
  localparam logic [7:0] SCA_MAX_OCTETS  = 8'd10;
  localparam logic [7:0] TYPE_FIELD_MASK = 8'h03;
  localparam logic [7:0] TYPE_DELIVER    = 8'h00;
  localparam int         ADDR_TYPE_BIT   = 7;
  localparam logic [7:0] CODING_8BIT     = 8'h04;
  localparam logic [3:0] STAMP_OCTETS    = 4'd7;
  localparam logic [3:0] FILLER_NIBBLE   = 4'hF;
  localparam logic [3:0] MAX_DECIMAL     = 4'd9;

  // Reset values of the configuration registers
  localparam logic [4:0] MAX_DIGITS_RESET = 5'd16;
  localparam logic [7:0] MAX_OCTETS_RESET = 8'd140;

  // One result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [3:0] status;
    logic       run_end;
  } result_t;

  // Up to three results per input beat, slot 0 first
  typedef result_t [2:0] result_set_t;

  // Parser state
  typedef struct packed {
    phase_t     phase;
    logic [3:0] skip_left;
    logic [3:0] addr_left;
    logic [7:0] msg_left;
    logic       digit_fault;
  } parse_state_t;

endpackage

`default_nettype wire

[rtl/sdp_step.sv]
// Per-octet decode: next parser state and the results one octet produces.
`default_nettype none

module sdp_step (
  input  sdp_pkg::parse_state_t cur,
  input  logic [7:0]            octet,
  input  logic                  eop,
  input  logic [4:0]            max_digits,
  input  logic [7:0]            max_octets,
  output sdp_pkg::parse_state_t nxt,
  output sdp_pkg::result_set_t  res,
  output logic [1:0]            res_count
);

  always_comb begin
    logic       st_valid;
    logic [3:0] st_code;
    logic       was_drain;
    logic [8:0] even;
    logic       last;
    logic [3:0] lo;
    logic [3:0] hi;
    logic       fault;
    logic       lo_v;
    logic       hi_v;
    logic       oct_v;
    logic [1:0] n;

    nxt       = cur;
    st_valid  = 1'b0;
    st_code   = sdp_pkg::ST_OK;
    was_drain = (cur.phase == sdp_pkg::PH_DRAIN);
    even      = {1'b0, octet} + {8'd0, octet[0]};
    last      = (cur.addr_left <= 4'd1);
    lo        = octet[3:0];
    hi        = octet[7:4];
    fault     = cur.digit_fault;
    lo_v      = 1'b0;
    hi_v      = 1'b0;
    oct_v     = 1'b0;
    n         = 2'd0;
    res       = '0;

    // phase update
    case (cur.phase)
      sdp_pkg::PH_SCA_LEN: begin
        if (octet > sdp_pkg::SCA_MAX_OCTETS) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_BAD_SCA_LEN;
        end else begin
          nxt.skip_left = octet[3:0];
          nxt.phase = (octet != 8'd0) ? sdp_pkg::PH_SCA_SKIP : sdp_pkg::PH_FIRST;
        end
      end
      sdp_pkg::PH_SCA_SKIP: begin
        nxt.skip_left = cur.skip_left - 4'd1;
        if (nxt.skip_left == 4'd0) nxt.phase = sdp_pkg::PH_FIRST;
      end
      sdp_pkg::PH_FIRST: begin
        if ((octet & sdp_pkg::TYPE_FIELD_MASK) != sdp_pkg::TYPE_DELIVER) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_NOT_DELIVER;
        end else begin
          nxt.phase = sdp_pkg::PH_ADDR_LEN;
        end
      end
      sdp_pkg::PH_ADDR_LEN: begin
        if (octet == 8'd0) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_BAD_ADDR_LEN;
        end else if (!eop) begin
          if (even > {4'd0, max_digits}) begin
            st_valid = 1'b1;
            st_code  = sdp_pkg::ST_BAD_ADDR_LEN;
          end else begin
            nxt.addr_left   = even[4:1];
            nxt.digit_fault = 1'b0;
            nxt.phase       = sdp_pkg::PH_ADDR_TYPE;
          end
        end
      end
      sdp_pkg::PH_ADDR_TYPE: begin
        if (!octet[sdp_pkg::ADDR_TYPE_BIT]) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_BAD_ADDR_TYPE;
        end else begin
          nxt.phase = sdp_pkg::PH_ADDR_DIGITS;
        end
      end
      sdp_pkg::PH_ADDR_DIGITS: begin
        // low nibble first; a filler F is allowed only as the last high nibble
        if (!fault) begin
          if (lo <= sdp_pkg::MAX_DECIMAL) lo_v = 1'b1;
          else fault = 1'b1;
        end
        if (!fault) begin
          if (hi <= sdp_pkg::MAX_DECIMAL) hi_v = 1'b1;
          else if (!(last && hi == sdp_pkg::FILLER_NIBBLE)) fault = 1'b1;
        end
        nxt.digit_fault = fault;
        nxt.addr_left   = cur.addr_left - 4'd1;
        if (last) begin
          nxt.addr_left = 4'd0;
          if (fault) begin
            st_valid = 1'b1;
            st_code  = sdp_pkg::ST_BAD_DIGIT;
          end else begin
            nxt.phase = sdp_pkg::PH_PID;
          end
        end
      end
      sdp_pkg::PH_PID: begin
        nxt.phase = sdp_pkg::PH_CODING;
      end
      sdp_pkg::PH_CODING: begin
        if (octet != sdp_pkg::CODING_8BIT) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_BAD_CODING;
        end else begin
          nxt.skip_left = sdp_pkg::STAMP_OCTETS;
          nxt.phase     = sdp_pkg::PH_STAMP;
        end
      end
      sdp_pkg::PH_STAMP: begin
        nxt.skip_left = cur.skip_left - 4'd1;
        if (nxt.skip_left == 4'd0) nxt.phase = sdp_pkg::PH_UDL;
      end
      sdp_pkg::PH_UDL: begin
        if (octet > max_octets) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_TOO_LONG;
        end else if (octet == 8'd0) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_OK;
        end else begin
          nxt.msg_left = octet;
          nxt.phase    = sdp_pkg::PH_MSG;
        end
      end
      sdp_pkg::PH_MSG: begin
        oct_v        = 1'b1;
        nxt.msg_left = cur.msg_left - 8'd1;
        if (nxt.msg_left == 8'd0) begin
          st_valid = 1'b1;
          st_code  = sdp_pkg::ST_OK;
        end
      end
      default: begin
        // draining until end of PDU
      end
    endcase

    // early end of PDU
    if (!st_valid && eop && !was_drain) begin
      st_valid = 1'b1;
      st_code  = sdp_pkg::ST_TRUNCATED;
    end

    if (st_valid) nxt.phase = eop ? sdp_pkg::PH_SCA_LEN : sdp_pkg::PH_DRAIN;
    else if (eop) nxt.phase = sdp_pkg::PH_SCA_LEN;

    if (nxt.phase == sdp_pkg::PH_SCA_LEN) begin
      nxt.skip_left   = 4'd0;
      nxt.addr_left   = 4'd0;
      nxt.msg_left    = 8'd0;
      nxt.digit_fault = 1'b0;
    end

    // pack results in order
    if (lo_v) begin
      res[n] = '{kind: sdp_pkg::KIND_DIGIT, value: {4'd0, lo},
                 status: sdp_pkg::ST_OK, run_end: 1'b0};
      n = n + 2'd1;
    end
    if (hi_v) begin
      res[n] = '{kind: sdp_pkg::KIND_DIGIT, value: {4'd0, hi},
                 status: sdp_pkg::ST_OK, run_end: 1'b0};
      n = n + 2'd1;
    end
    if (oct_v) begin
      res[n] = '{kind: sdp_pkg::KIND_OCTET, value: octet,
                 status: sdp_pkg::ST_OK, run_end: 1'b0};
      n = n + 2'd1;
    end
    if (st_valid) begin
      res[n] = '{kind: sdp_pkg::KIND_STATUS, value: 8'd0,
                 status: st_code, run_end: 1'b0};
      n = n + 2'd1;
    end
    if (n != 2'd0) res[n - 2'd1].run_end = 1'b1;

    res_count = n;
  end

endmodule

`default_nettype wire

[rtl/sdp_outbuf.sv]
// Result register: holds the results of one octet and hands them out one beat at a time.
`default_nettype none

module sdp_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sdp_pkg::result_set_t load_res,
  input  logic [1:0]           load_count,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdp_pkg::result_t     out_res
);

  sdp_pkg::result_set_t slots;
  logic [1:0]           head;
  logic [1:0]           count;

  // room for a new set once the last pending beat leaves
  assign can_load  = (count == 2'd0) || (count == 2'd1 && out_ready);
  assign out_valid = (count != 2'd0);
  assign out_res   = slots[head];

  // slots need no reset
  always_ff @(posedge clk) begin
    if (load) slots <= load_res;
  end

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      count <= 2'd0;
    end else if (load) begin
      head  <= 2'd0;
      count <= load_count;
    end else if (out_valid && out_ready) begin
      head  <= head + 2'd1;
      count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

[rtl/sms_deliver_pdu_parser_top.sv]
// Top level of the SMS-DELIVER PDU parser: config registers, parser state, result buffer.
`default_nettype none

// The parser takes one binary PDU octet per beat and decodes it in the cycle it is
// accepted; each octet yields zero to three result beats (sender digits, a message
// octet, a closing status). Results leave through a single output port at one beat
// per cycle while out_ready is high, so an octet with no result lets the next octet
// in on the next cycle, while an octet with results holds the input until its last
// result leaves. The next octet is accepted in the same cycle as the
// last pending result of the previous one. No clearing pass follows reset.
module sms_deliver_pdu_parser_top (
  input  logic       clk,
  input  logic       rst,
  // configuration writes
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // PDU octets in
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pdu_octet,
  input  logic       end_of_pdu,
  // results out
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [3:0] status,
  output logic       run_end
);

  logic [4:0]            max_sender_digits;
  logic [7:0]            max_message_octets;
  sdp_pkg::parse_state_t state;
  sdp_pkg::parse_state_t state_next;
  sdp_pkg::result_set_t  step_res;
  logic [1:0]            step_count;
  sdp_pkg::result_t      out_res;
  logic                  in_fire;

  assign in_fire = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sender_digits  <= sdp_pkg::MAX_DIGITS_RESET;
      max_message_octets <= sdp_pkg::MAX_OCTETS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sdp_pkg::CFG_MAX_SENDER_DIGITS:  max_sender_digits  <= cfg_data[4:0];
        sdp_pkg::CFG_MAX_MESSAGE_OCTETS: max_message_octets <= cfg_data;
        default: ;
      endcase
    end
  end

  // octet decode
  sdp_step u_step (
    .cur        (state),
    .octet      (pdu_octet),
    .eop        (end_of_pdu),
    .max_digits (max_sender_digits),
    .max_octets (max_message_octets),
    .nxt        (state_next),
    .res        (step_res),
    .res_count  (step_count)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= sdp_pkg::PH_SCA_LEN;
      state.skip_left   <= 4'd0;
      state.addr_left   <= 4'd0;
      state.msg_left    <= 8'd0;
      state.digit_fault <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // result buffer
  sdp_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire),
    .load_res   (step_res),
    .load_count (step_count),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign kind    = out_res.kind;
  assign value   = out_res.value;
  assign status  = out_res.status;
  assign run_end = out_res.run_end;

  // a status beat always closes the run of its octet
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sdp_pkg::KIND_STATUS |-> run_end)
    else $error("status beat without run_end");

  // digit and octet beats carry a zero status
  a_data_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != sdp_pkg::KIND_STATUS |-> status == sdp_pkg::ST_OK)
    else $error("non-status beat with non-zero status");

  // the final octet of a PDU returns the parser to the start
  a_eop_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_pdu |=> state.phase == sdp_pkg::PH_SCA_LEN)
    else $error("parser not restarted after end of PDU");

endmodule

`default_nettype wire

[tb/sdp_result_checker.sv]
// Result checker for the SMS-DELIVER PDU parser: tracks the parse, predicts and compares beats.
`timescale 1ns / 1ps

module sdp_result_checker
  import sdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] pdu_octet,
  input  logic       end_of_pdu,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  input  logic [3:0] status,
  input  logic       run_end,
  output int         failures,
  output int         pending
);

  // Shadow copy of the configuration and of the parse state
  logic [4:0] max_digits;
  logic [7:0] max_octets;
  phase_t     phase;
  logic [3:0] skip_left;
  logic [3:0] addr_left;
  logic [7:0] msg_left;
  logic       digit_fault;

  result_t expected_results [$];
  int      fail_count = 0;

  function automatic result_t make_result(input logic [1:0] k, input logic [7:0] v,
                                          input logic [3:0] s);
    result_t r;
    r.kind    = k;
    r.value   = v;
    r.status  = s;
    r.run_end = 1'b0;
    return r;
  endfunction

  task automatic clear_parse();
    phase       = PH_SCA_LEN;
    skip_left   = '0;
    addr_left   = '0;
    msg_left    = '0;
    digit_fault = 1'b0;
  endtask

  // Advance the parse by one octet and queue the beats it should produce
  task automatic parse_octet(input logic [7:0] o, input logic eop);
    result_t    found [3];
    int         n;
    int         even_len;
    logic       closing;
    logic       was_drain;
    logic       last;
    logic [3:0] close_code;
    logic [3:0] lo;
    logic [3:0] hi;
    n          = 0;
    closing    = 1'b0;
    close_code = ST_OK;
    was_drain  = (phase >= PH_DRAIN);
    lo         = o[3:0];
    hi         = o[7:4];

    case (phase)
      PH_SCA_LEN: begin
        if (o > SCA_MAX_OCTETS) begin
          closing = 1'b1; close_code = ST_BAD_SCA_LEN;
        end else begin
          skip_left = o[3:0];
          phase = (o != 8'd0) ? PH_SCA_SKIP : PH_FIRST;
        end
      end
      PH_SCA_SKIP: begin
        skip_left = skip_left - 4'd1;
        if (skip_left == 4'd0) phase = PH_FIRST;
      end
      PH_FIRST: begin
        if ((o & TYPE_FIELD_MASK) != TYPE_DELIVER) begin
          closing = 1'b1; close_code = ST_NOT_DELIVER;
        end else begin
          phase = PH_ADDR_LEN;
        end
      end
      PH_ADDR_LEN: begin
        // a final non-zero length falls through to truncation below
        if (o == 8'd0) begin
          closing = 1'b1; close_code = ST_BAD_ADDR_LEN;
        end else if (!eop) begin
          even_len = int'(o) + int'(o[0]);
          if (even_len > int'(max_digits)) begin
            closing = 1'b1; close_code = ST_BAD_ADDR_LEN;
          end else begin
            addr_left   = 4'(even_len / 2);
            digit_fault = 1'b0;
            phase       = PH_ADDR_TYPE;
          end
        end
      end
      PH_ADDR_TYPE: begin
        if (!o[ADDR_TYPE_BIT]) begin
          closing = 1'b1; close_code = ST_BAD_ADDR_TYPE;
        end else begin
          phase = PH_ADDR_DIGITS;
        end
      end
      PH_ADDR_DIGITS: begin
        last = (addr_left <= 4'd1);
        if (!digit_fault) begin
          if (lo <= MAX_DECIMAL) begin
            found[n] = make_result(KIND_DIGIT, {4'd0, lo}, ST_OK); n++;
          end else begin
            digit_fault = 1'b1;
          end
        end
        // only a trailing F in the last octet is filler
        if (!digit_fault) begin
          if (hi <= MAX_DECIMAL) begin
            found[n] = make_result(KIND_DIGIT, {4'd0, hi}, ST_OK); n++;
          end else if (!(last && hi == FILLER_NIBBLE)) begin
            digit_fault = 1'b1;
          end
        end
        addr_left = addr_left - 4'd1;
        if (last) begin
          addr_left = '0;
          if (digit_fault) begin
            closing = 1'b1; close_code = ST_BAD_DIGIT;
          end else begin
            phase = PH_PID;
          end
        end
      end
      PH_PID: phase = PH_CODING;
      PH_CODING: begin
        if (o != CODING_8BIT) begin
          closing = 1'b1; close_code = ST_BAD_CODING;
        end else begin
          skip_left = STAMP_OCTETS;
          phase = PH_STAMP;
        end
      end
      PH_STAMP: begin
        skip_left = skip_left - 4'd1;
        if (skip_left == 4'd0) phase = PH_UDL;
      end
      PH_UDL: begin
        if (o > max_octets) begin
          closing = 1'b1; close_code = ST_TOO_LONG;
        end else if (o == 8'd0) begin
          closing = 1'b1; close_code = ST_OK;
        end else begin
          msg_left = o;
          phase = PH_MSG;
        end
      end
      PH_MSG: begin
        found[n] = make_result(KIND_OCTET, o, ST_OK); n++;
        msg_left = msg_left - 8'd1;
        if (msg_left == 8'd0) begin
          closing = 1'b1; close_code = ST_OK;
        end
      end
      default: ;
    endcase

    // early end of the PDU, unless this octet already closed it
    if (!closing && eop && !was_drain) begin
      closing = 1'b1; close_code = ST_TRUNCATED;
    end

    if (closing) begin
      found[n] = make_result(KIND_STATUS, 8'd0, close_code); n++;
      phase = eop ? PH_SCA_LEN : PH_DRAIN;
    end else if (eop) begin
      phase = PH_SCA_LEN;
    end
    if (phase == PH_SCA_LEN) clear_parse();

    for (int i = 0; i < n; i++) begin
      if (i == n - 1) found[i].run_end = 1'b1;
      expected_results.push_back(found[i]);
    end
  endtask

  // Input beats are predicted before the output beat of the same edge is checked
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      max_digits = MAX_DIGITS_RESET;
      max_octets = MAX_OCTETS_RESET;
      clear_parse();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_SENDER_DIGITS) max_digits = cfg_data[4:0];
        else max_octets = cfg_data;
      end
      if (in_valid && in_ready) parse_octet(pdu_octet, end_of_pdu);
      if (out_valid && out_ready) begin
        got.kind    = kind;
        got.value   = value;
        got.status  = status;
        got.run_end = run_end;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected beat: expected none, got kind %0d value %0d",
                   $time, got.kind, got.value,
                   " status %0d run_end %0d", got.status, got.run_end);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.status !== want.status || got.run_end !== want.run_end) begin
            fail_count++;
            $display("%0t ns: beat mismatch: expected kind %0d value %0d status %0d",
                     $time, want.kind, want.value, want.status,
                     " run_end %0d, got kind %0d value %0d status %0d run_end %0d",
                     want.run_end, got.kind, got.value, got.status, got.run_end);
          end
        end
      end
    end
    pending  <= expected_results.size();
    failures <= fail_count;
  end

endmodule

[tb/sms_deliver_pdu_parser_top_test.sv]
// Testbench top for the SMS-DELIVER PDU parser: clock, reset, PDU stimulus, stalls and verdict.
`timescale 1ns / 1ps

module sms_deliver_pdu_parser_top_test;
  import sdp_pkg::*;

  typedef enum int {
    FLT_NONE,
    FLT_TRUNCATE,
    FLT_SCA_LEN,
    FLT_NOT_DELIVER,
    FLT_ADDR_ZERO,
    FLT_ADDR_LONG,
    FLT_ADDR_TYPE,
    FLT_DIGIT,
    FLT_CODING,
    FLT_TOO_LONG,
    FLT_TRAILING,
    FLT_CORRUPT,
    FLT_COUNT
  } pdu_fault_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       cfg_we     = 1'b0;
  logic       cfg_index  = 1'b0;
  logic [7:0] cfg_data   = 8'd0;
  logic       in_valid   = 1'b0;
  logic [7:0] pdu_octet  = 8'd0;
  logic       end_of_pdu = 1'b0;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] value;
  logic [3:0] status;
  logic       run_end;
  int         failures;
  int         pending;

  sms_deliver_pdu_parser_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pdu_octet  (pdu_octet),
    .end_of_pdu (end_of_pdu),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .value      (value),
    .status     (status),
    .run_end    (run_end)
  );

  sdp_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pdu_octet  (pdu_octet),
    .end_of_pdu (end_of_pdu),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .value      (value),
    .status     (status),
    .run_end    (run_end),
    .failures   (failures),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls: a mode held for a random stretch of cycles
  rx_mode_t   rx_mode      = RX_OPEN;
  int         rx_mode_left = 0;
  logic [7:0] rx_tick      = 8'd0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(16, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_tick <= rx_tick + 8'd1;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= rx_tick[2];
    endcase
  end

  // Current register values, for shaping well-formed PDUs
  int         cur_digits = int'(MAX_DIGITS_RESET);
  int         cur_octets = int'(MAX_OCTETS_RESET);
  int         burst_left = 0;
  logic [7:0] pdu_bytes [$];

  // Send one octet beat; bursts of random length with random gaps between them
  task automatic send_octet(input logic [7:0] o, input logic eop);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    pdu_octet  <= o;
    end_of_pdu <= eop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_pdu();
    for (int i = 0; i < pdu_bytes.size(); i++)
      send_octet(pdu_bytes[i], i == pdu_bytes.size() - 1);
  endtask

  // Write both registers once every pending beat has drained
  task automatic write_config(input int digits, input int octets);
    logic [7:0] d;
    logic [7:0] m;
    d = 8'(digits);
    m = 8'(octets);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_SENDER_DIGITS;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= CFG_MAX_MESSAGE_OCTETS;
    cfg_data  <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_digits = digits;
    cur_octets = octets;
  endtask

  // Build a PDU that is well formed under the current registers, then apply one fault
  task automatic build_pdu(input pdu_fault_t flt);
    int         sca_n;
    int         digits;
    int         addr_octets;
    int         first_digit;
    int         udl;
    int         cap;
    int         idx;
    logic [7:0] b;
    logic [3:0] lo;
    logic [3:0] hi;
    pdu_bytes.delete();

    // service centre address
    sca_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    b = (flt == FLT_SCA_LEN) ? 8'($urandom_range(11, 255)) : 8'(sca_n);
    pdu_bytes.push_back(b);
    repeat (sca_n) begin
      b = 8'($urandom);
      pdu_bytes.push_back(b);
    end

    // first octet
    b = 8'($urandom);
    b = b & ~TYPE_FIELD_MASK;
    if (flt == FLT_NOT_DELIVER) b[1:0] = 2'($urandom_range(1, 3));
    pdu_bytes.push_back(b);

    // sender address length and type
    digits = $urandom_range(1, cur_digits);
    if (digits[0] && digits + 1 > cur_digits) digits--;
    if (flt == FLT_ADDR_ZERO) b = 8'd0;
    else if (flt == FLT_ADDR_LONG) b = 8'($urandom_range(cur_digits + 1, 255));
    else b = 8'(digits);
    pdu_bytes.push_back(b);
    b = 8'($urandom);
    b[ADDR_TYPE_BIT] = (flt != FLT_ADDR_TYPE);
    pdu_bytes.push_back(b);

    // semi-octet digits, low nibble first
    addr_octets = (digits + 1) / 2;
    first_digit = pdu_bytes.size();
    for (int i = 0; i < addr_octets; i++) begin
      lo = 4'($urandom_range(0, 9));
      hi = 4'($urandom_range(0, 9));
      if (i == addr_octets - 1 && digits[0] && $urandom_range(0, 7) != 0) hi = FILLER_NIBBLE;
      pdu_bytes.push_back({hi, lo});
    end
    if (flt == FLT_DIGIT) begin
      idx = first_digit + $urandom_range(0, addr_octets - 1);
      b = pdu_bytes[idx];
      if ($urandom_range(0, 1) == 0) b[3:0] = 4'($urandom_range(10, 15));
      else b[7:4] = 4'($urandom_range(10, 15));
      pdu_bytes[idx] = b;
    end

    // PID, coding, timestamp
    b = 8'($urandom);
    pdu_bytes.push_back(b);
    if (flt == FLT_CODING) begin
      b = 8'($urandom);
      if (b == CODING_8BIT) b = ~CODING_8BIT;
    end else begin
      b = CODING_8BIT;
    end
    pdu_bytes.push_back(b);
    repeat (STAMP_OCTETS) begin
      b = 8'($urandom);
      pdu_bytes.push_back(b);
    end

    // user data length and message; most messages short, a few up to the limit
    if (flt == FLT_TOO_LONG && cur_octets < 255) begin
      b = 8'($urandom_range(cur_octets + 1, 255));
      pdu_bytes.push_back(b);
      repeat ($urandom_range(0, 3)) begin
        b = 8'($urandom);
        pdu_bytes.push_back(b);
      end
    end else begin
      cap = ($urandom_range(0, 19) == 0) ? cur_octets : ((cur_octets < 12) ? cur_octets : 12);
      udl = $urandom_range(0, cap);
      b = 8'(udl);
      pdu_bytes.push_back(b);
      repeat (udl) begin
        b = 8'($urandom);
        pdu_bytes.push_back(b);
      end
    end

    // faults that reshape the finished PDU
    case (flt)
      FLT_TRUNCATE: begin
        idx = $urandom_range(1, pdu_bytes.size() - 1);
        while (pdu_bytes.size() > idx) pdu_bytes.delete(pdu_bytes.size() - 1);
      end
      FLT_TRAILING: begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom);
          pdu_bytes.push_back(b);
        end
      end
      FLT_CORRUPT: begin
        idx = $urandom_range(0, pdu_bytes.size() - 1);
        b = 8'($urandom);
        pdu_bytes[idx] = b;
      end
      default: ;
    endcase
  endtask

  task automatic load_bytes(input logic [7:0] a [], input int count);
    pdu_bytes.delete();
    for (int i = 0; i < count; i++) pdu_bytes.push_back(a[i]);
  endtask

  initial begin
    logic [7:0] octs [];
    int         sent;
    int         r;
    int         noise_len;
    logic [7:0] b;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: shortest valid PDU, one digit with filler, empty message
    octs = '{8'h00, 8'hFC, 8'h01, 8'hFF, 8'hF9, 8'hFF, CODING_8BIT,
             8'h00, 8'h99, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00};
    load_bytes(octs, 15);
    send_pdu();
    // service centre length out of range
    octs = '{8'hFF};
    load_bytes(octs, 1);
    send_pdu();
    // message type not DELIVER
    octs = '{8'h00, 8'h03};
    load_bytes(octs, 2);
    send_pdu();
    // zero sender length
    octs = '{8'h00, 8'h00, 8'h00};
    load_bytes(octs, 3);
    send_pdu();
    // PDU ends on a non-zero sender length
    octs = '{8'h00, 8'h00, 8'h05};
    load_bytes(octs, 3);
    send_pdu();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_config(20, 255);
        1:       write_config(2, 0);
        2:       write_config(int'(MAX_DIGITS_RESET), int'(MAX_OCTETS_RESET));
        default: write_config($urandom_range(2, 20), $urandom_range(0, 255));
      endcase
      sent = 0;
      while (sent < 50) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // noise, always closed by an end mark so the next PDU starts clean
          noise_len = $urandom_range(1, 8);
          for (int i = 0; i < noise_len; i++) begin
            b = 8'($urandom);
            send_octet(b, (i == noise_len - 1) || ($urandom_range(0, 3) == 0));
          end
          sent += noise_len;
        end else begin
          if (r < 55) build_pdu(FLT_NONE);
          else build_pdu(pdu_fault_t'($urandom_range(1, FLT_COUNT - 1)));
          send_pdu();
          sent += pdu_bytes.size();
        end
      end
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("sms_deliver_pdu_parser_top regression: pass");
    end else begin
      $display("sms_deliver_pdu_parser_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("sms_deliver_pdu_parser_top regression: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/sdp_pkg.sv
rtl/sdp_step.sv
rtl/sdp_outbuf.sv
rtl/sms_deliver_pdu_parser_top.sv
tb/sdp_result_checker.sv
tb/sms_deliver_pdu_parser_top_test.sv
